// ===== hdl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types, constants and the microcode program of the sine evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

   // default configuration
   localparam int MAX_TERMS_DEF = 16;
   localparam int FRAC_BITS_DEF = 24;

   // fixed field widths
   localparam int ANGLE_W = 27;
   localparam int COUNT_W = 5;
   localparam int SINE_W  = 32;

   // integer headroom of the datapath words above the fraction bits
   localparam int HEAD_BITS = 9;

   // microcode program counter
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   // program steps
   localparam step_type STEP_MUL_XX   = 4'd0;
   localparam step_type STEP_WB_X2    = 4'd1;
   localparam step_type STEP_TEST     = 4'd2;
   localparam step_type STEP_MUL_X2   = 4'd3;
   localparam step_type STEP_WB_PART  = 4'd4;
   localparam step_type STEP_MUL_RCP  = 4'd5;
   localparam step_type STEP_WB_TERM  = 4'd6;
   localparam step_type STEP_ACC_LAST = 4'd7;
   localparam step_type STEP_OUT      = 4'd8;

   // multiplier operand sources
   typedef enum logic [1:0] {
      OPD_X,
      OPD_TERM,
      OPD_X2,
      OPD_RECIP
   } opd_sel_type;

   // writeback destinations
   typedef enum logic [1:0] {
      WB_NONE,
      WB_X2,
      WB_TERM
   } wb_dest_type;

   // jump conditions
   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_IF_END,
      JMP_IF_MORE
   } jump_type;

   // one control word of the program
   typedef struct packed {
      logic        issue;
      opd_sel_type a_sel;
      opd_sel_type b_sel;
      wb_dest_type wb_dest;
      logic        wb_negate;
      logic        acc;
      logic        cnt_inc;
      jump_type    jump;
      step_type    target;
      logic        done;
   } ctrl_word_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic loop_end;
   } dp_status_type;

   localparam ctrl_word_type NOP_WORD = '{
      issue:     1'b0,
      a_sel:     OPD_X,
      b_sel:     OPD_X,
      wb_dest:   WB_NONE,
      wb_negate: 1'b0,
      acc:       1'b0,
      cnt_inc:   1'b0,
      jump:      JMP_NONE,
      target:    STEP_MUL_XX,
      done:      1'b0
   };

   // microcode rom
   function automatic ctrl_word_type microcode(input step_type step);
      ctrl_word_type w;
      w = NOP_WORD;
      unique case (step)
         STEP_MUL_XX: begin
            w.issue = 1'b1;
            w.a_sel = OPD_X;
            w.b_sel = OPD_X;
         end
         STEP_WB_X2: begin
            w.wb_dest = WB_X2;
         end
         STEP_TEST: begin
            w.jump   = JMP_IF_END;
            w.target = STEP_ACC_LAST;
         end
         STEP_MUL_X2: begin
            w.issue   = 1'b1;
            w.a_sel   = OPD_TERM;
            w.b_sel   = OPD_X2;
            w.acc     = 1'b1;
            w.cnt_inc = 1'b1;
         end
         STEP_WB_PART: begin
            w.wb_dest = WB_TERM;
         end
         STEP_MUL_RCP: begin
            w.issue = 1'b1;
            w.a_sel = OPD_TERM;
            w.b_sel = OPD_RECIP;
         end
         STEP_WB_TERM: begin
            w.wb_dest   = WB_TERM;
            w.wb_negate = 1'b1;
            w.jump      = JMP_IF_MORE;
            w.target    = STEP_MUL_X2;
         end
         STEP_ACC_LAST: begin
            w.acc = 1'b1;
         end
         STEP_OUT: begin
            w.done = 1'b1;
         end
         default: begin
            w = NOP_WORD;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tse_req_if.sv =====
// ----------------------------------------------------------------------------
// tse_req_if
// Request channel: angle and term count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tse_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [tse_pkg::ANGLE_W-1:0] angle;
   logic [tse_pkg::COUNT_W-1:0]        term_count;

   modport source (output valid, output angle, output term_count, input ready);
   modport sink (input valid, input angle, input term_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/tse_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tse_rsp_if
// Response channel: saturated sine value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tse_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tse_pkg::SINE_W-1:0] sine_value;

   modport source (output valid, output sine_value, input ready);
   modport sink (input valid, input sine_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/tse_sequencer.sv =====
// ----------------------------------------------------------------------------
// tse_sequencer
// Step counter over the microcode rom, conditional jumps and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire tse_pkg::dp_status_type status,
   output logic                        start,
   output tse_pkg::ctrl_word_type      ctrl
);

   logic                   busy_ff, busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tse_pkg::step_type      step_ff, step_in;
   tse_pkg::ctrl_word_type word;
   logic                   stall;
   logic                   active;
   logic                   taken;

   // fetch the control word of the current step
   assign word   = tse_pkg::microcode(step_ff);
   assign stall  = word.done && rsp_valid_ff && !rsp_ready;
   assign active = busy_ff && !stall;
   assign ctrl   = active ? word : tse_pkg::NOP_WORD;

   assign req_ready = !busy_ff;
   assign start     = req_valid && !busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // jump decision
   always_comb begin
      unique case (word.jump)
         tse_pkg::JMP_IF_END:  taken = status.loop_end;
         tse_pkg::JMP_IF_MORE: taken = !status.loop_end;
         default:              taken = 1'b0;
      endcase
   end

   // next step, busy and result valid
   always_comb begin
      step_in      = step_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = tse_pkg::STEP_MUL_XX;
      end else if (active) begin
         if (word.done) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else if (taken) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + tse_pkg::step_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= tse_pkg::STEP_MUL_XX;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tse_datapath.sv =====
// ----------------------------------------------------------------------------
// tse_datapath
// Operand registers, shared multiplier with rounding writeback, accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_datapath #(
   parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF,
   parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               start,
   input  wire logic signed [tse_pkg::ANGLE_W-1:0] angle,
   input  wire logic [tse_pkg::COUNT_W-1:0]        term_count,
   input  wire tse_pkg::ctrl_word_type             ctrl,
   output tse_pkg::dp_status_type                  status,
   output logic signed [tse_pkg::SINE_W-1:0]       sine_value
);

   localparam int DW_FRAC = FRAC_BITS + tse_pkg::HEAD_BITS;
   localparam int DW      = (DW_FRAC > tse_pkg::ANGLE_W) ? DW_FRAC : tse_pkg::ANGLE_W + 1;
   localparam int SW      = DW + 1;
   localparam int CMPW    = (SW > tse_pkg::SINE_W) ? SW : tse_pkg::SINE_W + 1;
   localparam int CW      = $clog2(MAX_TERMS + 1);
   localparam int TAB_N   = 1 << CW;
   localparam int NCMP_W  = (CW > tse_pkg::COUNT_W) ? CW + 1 : tse_pkg::COUNT_W + 1;
   localparam logic [2*DW-1:0] HALF = (2*DW)'(1) << (FRAC_BITS - 1);
   localparam logic signed [CMPW-1:0] SAT_HI = CMPW'(64'sd2147483647);
   localparam logic signed [CMPW-1:0] SAT_LO = -CMPW'(64'sd2147483648);

   logic signed [DW-1:0]     x_ff, x_in;
   logic signed [DW-1:0]     x2_ff, x2_in;
   logic signed [DW-1:0]     term_ff, term_in;
   logic signed [SW-1:0]     sum_ff, sum_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            n_ff, n_in;
   logic [2*DW-1:0]          prod_ff, prod_in;
   logic                     prod_neg_ff, prod_neg_in;
   logic signed [tse_pkg::SINE_W-1:0] sine_value_ff, sine_value_in;

   logic [DW-1:0]            recip_tab [TAB_N];
   logic signed [DW-1:0]     a_op, b_op;
   logic [DW-1:0]            mag_a, mag_b;
   logic [2*DW-1:0]          prod_rnd;
   logic [DW-1:0]            rounded;
   logic signed [DW-1:0]     wb_val;
   logic signed [DW-1:0]     angle_ext;
   logic signed [CMPW-1:0]   sum_ext;

   // reciprocal table of 1/((2j)(2j+1)), rounded half up
   for (genvar j = 0; j < TAB_N; j++) begin : g_recip
      localparam longint unsigned D   = 64'(4 * j * j + 2 * j);
      localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
      localparam longint unsigned R   =
         (j >= 1 && j <= MAX_TERMS) ? (ONE + D / 2) / D : 64'd0;
      assign recip_tab[j] = DW'(R);
   end

   assign angle_ext = DW'(angle);

   // operand selection
   always_comb begin
      case (ctrl.a_sel)
         tse_pkg::OPD_TERM: a_op = term_ff;
         default:           a_op = x_ff;
      endcase
      case (ctrl.b_sel)
         tse_pkg::OPD_X2:    b_op = x2_ff;
         tse_pkg::OPD_RECIP: b_op = signed'(recip_tab[cnt_ff]);
         default:            b_op = x_ff;
      endcase
   end

   // sign-magnitude product
   assign mag_a = a_op[DW-1] ? unsigned'(-a_op) : unsigned'(a_op);
   assign mag_b = b_op[DW-1] ? unsigned'(-b_op) : unsigned'(b_op);

   // round half away from zero, then apply sign
   assign prod_rnd = prod_ff + HALF;
   assign rounded  = prod_rnd[FRAC_BITS +: DW];
   assign wb_val   = (prod_neg_ff ^ ctrl.wb_negate) ? -signed'(rounded) : signed'(rounded);

   // output saturation
   assign sum_ext = CMPW'(sum_ff);

   always_comb begin
      x_in          = x_ff;
      x2_in         = x2_ff;
      term_in       = term_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      prod_in       = prod_ff;
      prod_neg_in   = prod_neg_ff;
      sine_value_in = sine_value_ff;
      if (start) begin
         x_in    = angle_ext;
         term_in = angle_ext;
         sum_in  = '0;
         cnt_in  = '0;
         if (NCMP_W'(term_count) > NCMP_W'(MAX_TERMS)) begin
            n_in = CW'(MAX_TERMS);
         end else begin
            n_in = CW'(term_count);
         end
      end else begin
         if (ctrl.issue) begin
            prod_in     = (2*DW)'(mag_a) * (2*DW)'(mag_b);
            prod_neg_in = a_op[DW-1] ^ b_op[DW-1];
         end
         case (ctrl.wb_dest)
            tse_pkg::WB_X2:   x2_in   = wb_val;
            tse_pkg::WB_TERM: term_in = wb_val;
            default:          ;
         endcase
         if (ctrl.acc) begin
            sum_in = sum_ff + SW'(term_ff);
         end
         if (ctrl.cnt_inc) begin
            cnt_in = cnt_ff + CW'(1);
         end
         if (ctrl.done) begin
            if (sum_ext > SAT_HI) begin
               sine_value_in = tse_pkg::SINE_W'(SAT_HI);
            end else if (sum_ext < SAT_LO) begin
               sine_value_in = tse_pkg::SINE_W'(SAT_LO);
            end else begin
               sine_value_in = tse_pkg::SINE_W'(sum_ext);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      x2_ff         <= x2_in;
      term_ff       <= term_in;
      sum_ff        <= sum_in;
      cnt_ff        <= cnt_in;
      n_ff          <= n_in;
      prod_ff       <= prod_in;
      prod_neg_ff   <= prod_neg_in;
      sine_value_ff <= sine_value_in;
   end

   assign status.loop_end = (cnt_ff == n_ff);
   assign sine_value      = sine_value_ff;

endmodule

`default_nettype wire

// ===== hdl/taylor_sine_evaluator.sv =====
// ----------------------------------------------------------------------------
// taylor_sine_evaluator
// Truncated Maclaurin sine series in signed fixed point.
// ----------------------------------------------------------------------------
// Each request carries an angle x (27 bits, FRAC_BITS fraction bits) and a
// term count n, clamped to MAX_TERMS; the response is x plus n alternating
// series terms, saturated to 32 bits. One request is worked on at a time:
// a small microcode program drives a single shared multiplier, whose product
// is registered and written back rounded in the following step; each term
// takes two multiply/writeback pairs. The next request is taken while the
// previous response waits in its output register.
`default_nettype none

module taylor_sine_evaluator #(
   parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF,
   parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   tse_req_if.sink   req,
   tse_rsp_if.source rsp
);

   logic                   start;
   tse_pkg::ctrl_word_type ctrl;
   tse_pkg::dp_status_type status;

   // program sequencer
   tse_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .start     (start),
      .ctrl      (ctrl)
   );

   // arithmetic datapath
   tse_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .start      (start),
      .angle      (req.angle),
      .term_count (req.term_count),
      .ctrl       (ctrl),
      .status     (status),
      .sine_value (rsp.sine_value)
   );

endmodule

`default_nettype wire
